>>> rtl/core/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define STQ_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("stq assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define STQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("stq assertion failed");

`endif

>>> rtl/core/stq_pkg.sv
`timescale 1ns / 1ps

package stq_pkg;

  localparam int POOL_SLOTS = 16;
  localparam int SLOT_W     = $clog2(POOL_SLOTS);
  localparam int CNT_W      = $clog2(POOL_SLOTS + 1);
  localparam int TICK_W     = 64;
  localparam int FREQ_W     = 32;
  localparam int DELAY_W    = 32;
  localparam int TAG_W      = 32;
  localparam int STATUS_W   = 2;

  localparam logic [FREQ_W-1:0] FREQ_RESET = 32'd19200000;

  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_FREE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_ADDED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FREED = 2'd2;

  typedef struct packed {
    logic                load;
    logic                mul;
    logic                add;
    logic                store;
    logic                pos_clr;
    logic                pos_inc;
    logic                ins;
    logic                unlink;
    logic                emit;
    logic [STATUS_W-1:0] emit_status;
  } ctrl_cmd_t;

  typedef struct packed {
    logic full;
    logic fslot_busy;
    logic pos_end;
    logic advance;
    logic match;
  } dp_stat_t;

endpackage

>>> rtl/core/stq_dp.sv
`timescale 1ns / 1ps

module stq_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [stq_pkg::FREQ_W-1:0]    cfg_data,
  input  logic [stq_pkg::TICK_W-1:0]    in_now_ticks,
  input  logic [stq_pkg::DELAY_W-1:0]   in_delay_seconds,
  input  logic [stq_pkg::TAG_W-1:0]     in_entry_tag,
  input  logic [stq_pkg::SLOT_W-1:0]    in_slot_to_free,
  input  stq_pkg::ctrl_cmd_t            cmd,
  output stq_pkg::dp_stat_t             stat,
  output logic                          out_valid,
  output logic [stq_pkg::STATUS_W-1:0]  out_status,
  output logic [stq_pkg::SLOT_W-1:0]    out_slot_index,
  output logic                          out_new_head,
  output logic [stq_pkg::TICK_W-1:0]    out_timeout_ticks
);

  logic [stq_pkg::FREQ_W-1:0]     freq_r;
  logic [stq_pkg::TICK_W-1:0]     now_r;
  logic [stq_pkg::DELAY_W-1:0]    delay_r;
  logic [stq_pkg::TAG_W-1:0]      tag_r;
  logic [stq_pkg::SLOT_W-1:0]     fslot_r;
  logic [stq_pkg::TICK_W-1:0]     product_r;
  logic [stq_pkg::TICK_W-1:0]     exp_r;
  logic [stq_pkg::SLOT_W-1:0]     free_slot_r;
  logic                           full_r;
  logic [stq_pkg::CNT_W-1:0]      pos_r;
  logic [stq_pkg::CNT_W-1:0]      len_r;
  logic [stq_pkg::POOL_SLOTS-1:0] busy_r;
  logic [stq_pkg::SLOT_W-1:0]     q_r   [stq_pkg::POOL_SLOTS];
  logic [stq_pkg::SLOT_W-1:0]     q_nxt [stq_pkg::POOL_SLOTS];
  logic [stq_pkg::TICK_W-1:0]     exp_mem [stq_pkg::POOL_SLOTS];
  logic [stq_pkg::TAG_W-1:0]      tag_mem [stq_pkg::POOL_SLOTS];
  logic [stq_pkg::TICK_W-1:0]     rdata_r;
  logic                           out_valid_r;
  logic [stq_pkg::STATUS_W-1:0]   out_status_r;
  logic [stq_pkg::SLOT_W-1:0]     out_slot_r;
  logic                           out_head_r;
  logic [stq_pkg::TICK_W-1:0]     out_tmo_r;

  logic [stq_pkg::SLOT_W-1:0]     free_slot;
  logic                           free_found;
  logic                           head_pos;

  // lowest free slot
  always_comb begin
    free_slot  = '0;
    free_found = 1'b0;
    for (int i = stq_pkg::POOL_SLOTS - 1; i >= 0; i--) begin
      if (!busy_r[i]) begin
        free_slot  = stq_pkg::SLOT_W'(i);
        free_found = 1'b1;
      end
    end
  end

  assign head_pos = (pos_r == '0);

  always_comb begin
    stat.full       = full_r;
    stat.fslot_busy = busy_r[fslot_r];
    stat.pos_end    = (pos_r == len_r);
    stat.advance    = head_pos ? (rdata_r <= exp_r) : (rdata_r < exp_r);
    stat.match      = (q_r[pos_r[stq_pkg::SLOT_W-1:0]] == fslot_r);
  end

  always_comb begin
    q_nxt = q_r;
    if (cmd.ins) begin
      for (int k = 1; k < stq_pkg::POOL_SLOTS; k++) begin
        if (stq_pkg::CNT_W'(k) > pos_r) begin
          q_nxt[k] = q_r[k-1];
        end
      end
      q_nxt[pos_r[stq_pkg::SLOT_W-1:0]] = free_slot_r;
    end else if (cmd.unlink) begin
      for (int j = 0; j < stq_pkg::POOL_SLOTS - 1; j++) begin
        if (stq_pkg::CNT_W'(j) >= pos_r) begin
          q_nxt[j] = q_r[j+1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      freq_r      <= stq_pkg::FREQ_RESET;
      busy_r      <= '0;
      len_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        freq_r <= cfg_data;
      end
      if (cmd.store) begin
        busy_r[free_slot_r] <= 1'b1;
      end else if (cmd.unlink) begin
        busy_r[fslot_r] <= 1'b0;
      end
      if (cmd.ins) begin
        len_r <= len_r + 1'b1;
      end else if (cmd.unlink) begin
        len_r <= len_r - 1'b1;
      end
      out_valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      now_r   <= in_now_ticks;
      delay_r <= in_delay_seconds;
      tag_r   <= in_entry_tag;
      fslot_r <= in_slot_to_free;
    end
    if (cmd.mul) begin
      product_r   <= stq_pkg::TICK_W'(delay_r) * stq_pkg::TICK_W'(freq_r);
      free_slot_r <= free_slot;
      full_r      <= !free_found || (len_r >= stq_pkg::CNT_W'(stq_pkg::POOL_SLOTS));
    end
    if (cmd.add) begin
      exp_r <= now_r + product_r;
    end
    if (cmd.pos_clr) begin
      pos_r <= '0;
    end else if (cmd.pos_inc) begin
      pos_r <= pos_r + 1'b1;
    end
    if (cmd.emit) begin
      out_status_r <= cmd.emit_status;
      out_head_r   <= 1'b0;
      out_tmo_r    <= '0;
      case (cmd.emit_status)
        stq_pkg::ST_ADDED: begin
          out_slot_r <= free_slot_r;
          if (head_pos) begin
            out_head_r <= 1'b1;
            out_tmo_r  <= product_r;
          end
        end
        stq_pkg::ST_FREED: begin
          out_slot_r <= fslot_r;
        end
        default: begin
          out_slot_r <= '0;
        end
      endcase
    end
  end

  // expiry and tag store
  always_ff @(posedge clk) begin
    if (cmd.store) begin
      exp_mem[free_slot_r] <= exp_r;
      tag_mem[free_slot_r] <= tag_r;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= exp_mem[q_r[pos_r[stq_pkg::SLOT_W-1:0]]];
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_slot_index    = out_slot_r;
  assign out_new_head      = out_head_r;
  assign out_timeout_ticks = out_tmo_r;

endmodule

>>> rtl/core/stq_ctrl.sv
`timescale 1ns / 1ps

module stq_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                in_command,
  input  stq_pkg::dp_stat_t   stat,
  output stq_pkg::ctrl_cmd_t  cmd,
  output logic                busy
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_MUL    = 4'd1;
  localparam logic [3:0] S_ADD    = 4'd2;
  localparam logic [3:0] S_STORE  = 4'd3;
  localparam logic [3:0] S_RD     = 4'd4;
  localparam logic [3:0] S_CMP    = 4'd5;
  localparam logic [3:0] S_INS    = 4'd6;
  localparam logic [3:0] S_FCHK   = 4'd7;
  localparam logic [3:0] S_FIND   = 4'd8;
  localparam logic [3:0] S_UNLINK = 4'd9;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = (in_command == stq_pkg::CMD_FREE) ? S_FCHK : S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_ADD;
      end
      S_ADD: begin
        cmd.add = 1'b1;
        if (stat.full) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = stq_pkg::ST_FULL;
          state_nxt       = S_IDLE;
        end else begin
          state_nxt = S_STORE;
        end
      end
      S_STORE: begin
        cmd.store   = 1'b1;
        cmd.pos_clr = 1'b1;
        state_nxt   = S_RD;
      end
      S_RD: begin
        state_nxt = stat.pos_end ? S_INS : S_CMP;
      end
      S_CMP: begin
        if (stat.advance) begin
          cmd.pos_inc = 1'b1;
          state_nxt   = S_RD;
        end else begin
          state_nxt = S_INS;
        end
      end
      S_INS: begin
        cmd.ins         = 1'b1;
        cmd.emit        = 1'b1;
        cmd.emit_status = stq_pkg::ST_ADDED;
        state_nxt       = S_IDLE;
      end
      S_FCHK: begin
        if (stat.fslot_busy) begin
          cmd.pos_clr = 1'b1;
          state_nxt   = S_FIND;
        end else begin
          cmd.emit        = 1'b1;
          cmd.emit_status = stq_pkg::ST_FREED;
          state_nxt       = S_IDLE;
        end
      end
      S_FIND: begin
        if (stat.pos_end) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = stq_pkg::ST_FREED;
          state_nxt       = S_IDLE;
        end else if (stat.match) begin
          state_nxt = S_UNLINK;
        end else begin
          cmd.pos_inc = 1'b1;
        end
      end
      S_UNLINK: begin
        cmd.unlink      = 1'b1;
        cmd.emit        = 1'b1;
        cmd.emit_status = stq_pkg::ST_FREED;
        state_nxt       = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

>>> rtl/core/sorted_timer_event_queue_unit.sv
`timescale 1ns / 1ps
// Sequence: an add loads, multiplies, adds, stores, then walks the queue (read and compare
//   per entry) and inserts; a full pool ends after the add step. A free ends after the busy
//   check for an idle slot, else it searches the queue for the slot and unlinks it.
// Throughput: one item at a time; a new start is taken in the cycle the result shows.
//   Results show one cycle on out_valid; no receiver stall.
// Reset (rst_n low, synchronous): pool empty, queue length 0, tick_frequency 19200000.

module sorted_timer_event_queue_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_command,
  input  logic [stq_pkg::TICK_W-1:0]    in_now_ticks,
  input  logic [stq_pkg::DELAY_W-1:0]   in_delay_seconds,
  input  logic [stq_pkg::TAG_W-1:0]     in_entry_tag,
  input  logic [stq_pkg::SLOT_W-1:0]    in_slot_to_free,
  output logic                          out_valid,
  output logic [stq_pkg::STATUS_W-1:0]  out_status,
  output logic [stq_pkg::SLOT_W-1:0]    out_slot_index,
  output logic                          out_new_head,
  output logic [stq_pkg::TICK_W-1:0]    out_timeout_ticks,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [stq_pkg::FREQ_W-1:0]    cfg_data
);

  stq_pkg::ctrl_cmd_t cmd;
  stq_pkg::dp_stat_t  stat;

  assign cfg_ready = 1'b1;

  stq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_command (in_command),
    .stat       (stat),
    .cmd        (cmd),
    .busy       (busy)
  );

  stq_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_valid & cfg_ready),
    .cfg_data          (cfg_data),
    .in_now_ticks      (in_now_ticks),
    .in_delay_seconds  (in_delay_seconds),
    .in_entry_tag      (in_entry_tag),
    .in_slot_to_free   (in_slot_to_free),
    .cmd               (cmd),
    .stat              (stat),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_slot_index    (out_slot_index),
    .out_new_head      (out_new_head),
    .out_timeout_ticks (out_timeout_ticks)
  );

endmodule

>>> rtl/core/stq_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module stq_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic                          out_valid,
  input logic [stq_pkg::STATUS_W-1:0]  out_status,
  input logic [stq_pkg::SLOT_W-1:0]    out_slot_index,
  input logic                          out_new_head,
  input logic [stq_pkg::TICK_W-1:0]    out_timeout_ticks
);

  logic status_ok;
  logic full_clean;

  assign status_ok  = (out_status == stq_pkg::ST_ADDED) || (out_status == stq_pkg::ST_FULL) ||
                      (out_status == stq_pkg::ST_FREED);
  assign full_clean = (out_slot_index == '0) && !out_new_head;

  `STQ_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `STQ_ASSERT_NEXT(a_one_cycle_result, out_valid, !out_valid)
  `STQ_ASSERT_NOW(a_status_code, out_valid, status_ok)
  `STQ_ASSERT_NOW(a_full_clean, out_valid && out_status == stq_pkg::ST_FULL, full_clean)
  `STQ_ASSERT_NOW(a_tmo_head_only, out_valid && !out_new_head, out_timeout_ticks == '0)

endmodule

bind sorted_timer_event_queue_unit stq_checker u_stq_checker (.*);
